// ===== src/ppte_pkg.sv =====
`timescale 1ns / 1ps

package ppte_pkg;

   // Fraction bits of the segment length coming out of the square root.
   localparam int LEN_FRAC_BITS = 8;

   // Fixed result widths.
   localparam int SEG_BITS   = 32;
   localparam int TOTAL_BITS = 48;

   // Speed setting registers and the divisor 12*setting + 2800.
   localparam int SETTING_BITS  = 10;
   localparam int DIV_BITS      = 14;
   localparam int SPEED_SCALE   = 12;
   localparam int SPEED_OFFSET  = 2800;
   localparam int CUT_RESET     = 100;
   localparam int TRAVEL_RESET  = 100;

   // Register map of the configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CUT_SPEED    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRAVEL_SPEED = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

// ===== src/plot_path_time_estimator.sv =====
`timescale 1ns / 1ps

// Plotter job time estimator. Each input beat carries one point; the block returns one
// result beat with the time of the segment from the previous point (seconds, TIME_FRAC_BITS
// fraction bits, clamped to 32 bits) and the saturating running total. One point is worked
// on at a time: a bit-serial sum of squares, a bit-serial square root and a restoring
// divide, one bit per cycle each. A finished result waits in the output register, and the
// next point may be taken while it does. The user must write settings through the csr port
// only while no point is in flight; the block itself does not enforce this.
module plot_path_time_estimator #(
   parameter int COORD_BITS     = 16,
   parameter int TIME_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_BITS-1:0]          req_point_x,
   input  logic signed [COORD_BITS-1:0]          req_point_y,
   input  logic                                  req_pen_down,
   input  logic                                  req_start_job,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ppte_pkg::SEG_BITS-1:0]         rsp_segment_time,
   output logic [ppte_pkg::TOTAL_BITS-1:0]       rsp_total_time,
   output logic                                  rsp_total_saturated,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ppte_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ppte_pkg::SETTING_BITS-1:0]     csr_wdata
);

   localparam int STEPS    = COORD_BITS + ppte_pkg::LEN_FRAC_BITS + 1;
   localparam int NUM_BITS = STEPS + TIME_FRAC_BITS - ppte_pkg::LEN_FRAC_BITS;
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);
   localparam int SEGB     = ppte_pkg::SEG_BITS;
   localparam int TOTB     = ppte_pkg::TOTAL_BITS;
   localparam int DIVB     = ppte_pkg::DIV_BITS;

   ppte_pkg::state_type state_ff, state_in;

   logic [ppte_pkg::SETTING_BITS-1:0] cut_ff;
   logic [ppte_pkg::SETTING_BITS-1:0] travel_ff;

   logic [COORD_BITS-1:0]   prev_x_ff;
   logic [COORD_BITS-1:0]   prev_y_ff;
   logic [TOTB-1:0]         acc_ff;

   logic [COORD_BITS-1:0]   dx_ff, dy_ff;
   logic [COORD_BITS-1:0]   mx_ff, my_ff;
   logic [COORD_BITS:0]     sq_hi_ff;
   logic [COORD_BITS-1:0]   sq_lo_ff;
   logic [DIVB-1:0]         divisor_ff;
   logic [CNT_BITS-1:0]     cnt_ff;

   logic [NUM_BITS-1:0]     dvd_ff;
   logic [DIVB-1:0]         drem_ff;
   logic [SEGB-1:0]         quo_ff;
   logic                    ovf_ff;

   logic                    rsp_valid_ff;
   logic [SEGB-1:0]         rsp_seg_ff;
   logic [TOTB-1:0]         rsp_total_ff;
   logic                    rsp_sat_ff;

   logic                    accept;
   logic                    out_free;
   logic                    last_step;

   logic [COORD_BITS-1:0]   base_x, base_y;
   logic [COORD_BITS:0]     diff_x, diff_y;
   logic [COORD_BITS-1:0]   abs_x, abs_y;
   logic [ppte_pkg::SETTING_BITS-1:0] setting;
   logic [DIVB-1:0]         divisor;

   logic [COORD_BITS+1:0]   sq_sum;
   logic [2*STEPS-1:0]      radicand;
   logic                    root_done;
   logic [STEPS-1:0]        root;

   logic [DIVB:0]           div_trial;
   logic                    div_fits;
   logic [DIVB:0]           div_diff;

   logic [SEGB-1:0]         seg_time;
   logic [TOTB:0]           total_sum;
   logic [TOTB-1:0]         total_next;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_step = (cnt_ff == CNT_BITS'(1));

   // Distances from the previous point, or from the origin when a job starts.
   always_comb begin
      base_x  = req_start_job ? '0 : prev_x_ff;
      base_y  = req_start_job ? '0 : prev_y_ff;
      diff_x  = {req_point_x[COORD_BITS-1], req_point_x} - {base_x[COORD_BITS-1], base_x};
      diff_y  = {req_point_y[COORD_BITS-1], req_point_y} - {base_y[COORD_BITS-1], base_y};
      abs_x   = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
      abs_y   = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
      setting = req_pen_down ? cut_ff : travel_ff;
      divisor = DIVB'(setting) * DIVB'(ppte_pkg::SPEED_SCALE)
              + DIVB'(ppte_pkg::SPEED_OFFSET);
   end

   // Shift-and-add for dx*dx + dy*dy: both partial products enter the upper half together,
   // and the low bits of the sum drop out one per cycle.
   always_comb begin
      sq_sum = (COORD_BITS+2)'(sq_hi_ff)
             + (mx_ff[0] ? (COORD_BITS+2)'(dx_ff) : '0)
             + (my_ff[0] ? (COORD_BITS+2)'(dy_ff) : '0);
      radicand = (2*STEPS)'({sq_hi_ff, sq_lo_ff}) << (2 * ppte_pkg::LEN_FRAC_BITS);
   end

   ppte_isqrt #(
      .STEPS(STEPS)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ppte_pkg::ST_ROOT_GO),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   always_comb begin
      div_trial = {drem_ff, dvd_ff[NUM_BITS-1]};
      div_fits  = (div_trial >= (DIVB+1)'(divisor_ff));
      div_diff  = div_trial - (DIVB+1)'(divisor_ff);
   end

   always_comb begin
      seg_time   = ovf_ff ? '1 : quo_ff;
      total_sum  = (TOTB+1)'(acc_ff) + (TOTB+1)'(seg_time);
      total_next = total_sum[TOTB] ? '1 : total_sum[TOTB-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppte_pkg::ST_IDLE: begin
            if (accept) state_in = ppte_pkg::ST_SQUARE;
         end
         ppte_pkg::ST_SQUARE: begin
            if (last_step) state_in = ppte_pkg::ST_ROOT_GO;
         end
         ppte_pkg::ST_ROOT_GO: begin
            state_in = ppte_pkg::ST_ROOT_WAIT;
         end
         ppte_pkg::ST_ROOT_WAIT: begin
            if (root_done) state_in = ppte_pkg::ST_DIVIDE;
         end
         ppte_pkg::ST_DIVIDE: begin
            if (last_step) state_in = ppte_pkg::ST_FINISH;
         end
         ppte_pkg::ST_FINISH: begin
            if (out_free) state_in = ppte_pkg::ST_IDLE;
         end
         default: begin
            state_in = ppte_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppte_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Settings, job state and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cut_ff       <= ppte_pkg::SETTING_BITS'(ppte_pkg::CUT_RESET);
         travel_ff    <= ppte_pkg::SETTING_BITS'(ppte_pkg::TRAVEL_RESET);
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               ppte_pkg::CSR_CUT_SPEED:    cut_ff    <= csr_wdata;
               ppte_pkg::CSR_TRAVEL_SPEED: travel_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (accept) begin
            prev_x_ff <= req_point_x;
            prev_y_ff <= req_point_y;
            if (req_start_job) acc_ff <= '0;
         end
         if (state_ff == ppte_pkg::ST_FINISH && out_free) begin
            acc_ff       <= total_next;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         if (accept) begin
            cnt_ff <= CNT_BITS'(COORD_BITS);
         end else if (state_ff == ppte_pkg::ST_ROOT_WAIT && root_done) begin
            cnt_ff <= CNT_BITS'(NUM_BITS);
         end else if (state_ff == ppte_pkg::ST_SQUARE || state_ff == ppte_pkg::ST_DIVIDE) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff      <= abs_x;
         dy_ff      <= abs_y;
         mx_ff      <= abs_x;
         my_ff      <= abs_y;
         sq_hi_ff   <= '0;
         sq_lo_ff   <= '0;
         divisor_ff <= divisor;
      end else if (state_ff == ppte_pkg::ST_SQUARE) begin
         mx_ff    <= mx_ff >> 1;
         my_ff    <= my_ff >> 1;
         sq_hi_ff <= sq_sum[COORD_BITS+1:1];
         sq_lo_ff <= {sq_sum[0], sq_lo_ff[COORD_BITS-1:1]};
      end
   end

   // Restoring divide of length * 2^(TIME_FRAC_BITS-8) by the divisor; quotient bits past
   // the 32-bit result only set the overflow flag.
   always_ff @(posedge clock) begin
      if (state_ff == ppte_pkg::ST_ROOT_WAIT && root_done) begin
         dvd_ff  <= NUM_BITS'(root) << (TIME_FRAC_BITS - ppte_pkg::LEN_FRAC_BITS);
         drem_ff <= '0;
         quo_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else if (state_ff == ppte_pkg::ST_DIVIDE) begin
         dvd_ff  <= dvd_ff << 1;
         drem_ff <= div_fits ? div_diff[DIVB-1:0] : div_trial[DIVB-1:0];
         quo_ff  <= {quo_ff[SEGB-2:0], div_fits};
         ovf_ff  <= ovf_ff | quo_ff[SEGB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ppte_pkg::ST_FINISH && out_free) begin
         rsp_seg_ff   <= seg_time;
         rsp_total_ff <= total_next;
         rsp_sat_ff   <= (total_next == {TOTB{1'b1}});
      end
   end

   assign req_stall           = (state_ff != ppte_pkg::ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_segment_time    = rsp_seg_ff;
   assign rsp_total_time      = rsp_total_ff;
   assign rsp_total_saturated = rsp_sat_ff;

endmodule

// ===== src/ppte_isqrt.sv =====
`timescale 1ns / 1ps

module ppte_isqrt #(
   parameter int STEPS = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2*STEPS-1:0]   radicand,
   output logic                 done,
   output logic [STEPS-1:0]     root
);

   localparam int REM_BITS = STEPS + 3;
   localparam int CNT_BITS = $clog2(STEPS + 1);

   logic [2*STEPS-1:0]  rad_ff;
   logic [REM_BITS-1:0] rem_ff;
   logic [STEPS-1:0]    root_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff;
   logic                done_ff;

   logic [REM_BITS-1:0] rem_shift;
   logic [REM_BITS-1:0] trial;
   logic                fits;

   // One result bit per cycle: bring down the next two radicand bits and try 4*root+1.
   always_comb begin
      rem_shift = {rem_ff[REM_BITS-3:0], rad_ff[2*STEPS-1 -: 2]};
      trial     = REM_BITS'({root_ff, 2'b01});
      fits      = (rem_shift >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[2*STEPS-3:0], 2'b00};
         rem_ff  <= fits ? (rem_shift - trial) : rem_shift;
         root_ff <= {root_ff[STEPS-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
